// File: hdl/shell_argument_tokenizer_macros.svh
// Assertion macros for the tokenizer modules; only sat_queue uses them.
`ifndef SHELL_ARGUMENT_TOKENIZER_MACROS_SVH
`define SHELL_ARGUMENT_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, disabled while reset is held.
`define SAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// Next-cycle implication, sampled on clk, disabled while reset is held.
`define SAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define SAT_ASSERT_NOW(label, ante, cons)
`define SAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/sat_pkg.sv
// Package with the codes, types and helpers of the argument tokenizer.
`timescale 1ns / 1ps

package sat_pkg;

    // Lexer modes.
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_TOKEN   = 3'd1;
    localparam logic [2:0] MODE_SQ      = 3'd2;
    localparam logic [2:0] MODE_DQ      = 3'd3;
    localparam logic [2:0] MODE_DQ_BS   = 3'd4;
    localparam logic [2:0] MODE_BS      = 3'd5;
    localparam logic [2:0] MODE_COMMENT = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    // Characters that steer the lexer.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Up to three results follow from one input byte.
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // Depth of the queue between the lexer and the serialiser.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } res_t;

    // All results of one input byte; cnt is never zero once queued.
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        res_t [MAX_RES-1:0]     res;
    } bundle_t;

    // Appends one result to a bundle; data is kept only for argument bytes.
    function automatic bundle_t add_res(bundle_t b, logic [1:0] k, logic [7:0] d);
        bundle_t r;
        r = b;
        r.res[b.cnt[IDX_W-1:0]].kind = k;
        r.res[b.cnt[IDX_W-1:0]].data = (k == KIND_BYTE) ? d : 8'd0;
        r.cnt = b.cnt + CNT_W'(1);
        return r;
    endfunction

endpackage

// File: hdl/shell_argument_tokenizer.sv
// Top level of the streaming shell argument tokenizer.
//
//   channel   handshake          payload
//   input     push / full        in_byte, last_byte
//   results   empty / pop        kind, out_byte, run_end
//
// One input byte is taken per cycle while full is low; the lexer decides all
// results of a byte in that cycle and queues them as one bundle.
// The serialiser delivers one result per beat, so a byte with k results takes
// k beats on the output side; the four-bundle queue absorbs the difference.
// Bytes that cause no result never enter the queue.
// Reset returns the lexer to between tokens and empties the queue.
`timescale 1ns / 1ps

module shell_argument_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       run_end
);
    import sat_pkg::*;

    logic    take;
    logic    q_wr_en;
    bundle_t q_wr_data;
    logic    q_rd_en;
    bundle_t q_head;

    assign take = push && !full;

    sat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .wr_en     (q_wr_en),
        .wr_data   (q_wr_data)
    );

    sat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .full    (full),
        .empty   (empty)
    );

    sat_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (empty),
        .pop      (pop),
        .q_rd_en  (q_rd_en),
        .kind     (kind),
        .out_byte (out_byte),
        .run_end  (run_end)
    );

endmodule

// File: hdl/sat_front.sv
// Lexer front end: holds the mode and turns each byte into a bundle of results.
`timescale 1ns / 1ps

module sat_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       in_byte,
    input  logic             last_byte,
    output logic             wr_en,
    output sat_pkg::bundle_t wr_data
);
    import sat_pkg::*;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       tok_reg;
    logic       tok_next;
    bundle_t    bnd;

    always_comb
    begin
        logic [2:0] m;
        logic       t;
        bundle_t    b;
        m = mode_reg;
        t = tok_reg;
        b = '0;
        case (mode_reg)
            MODE_SQ:
            begin
                if (in_byte == CH_SQUOTE)
                    m = MODE_TOKEN;
                else
                    b = add_res(b, KIND_BYTE, in_byte);
            end
            MODE_DQ:
            begin
                if (in_byte == CH_BSLASH)
                    m = MODE_DQ_BS;
                else if (in_byte == CH_DQUOTE)
                    m = MODE_TOKEN;
                else
                    b = add_res(b, KIND_BYTE, in_byte);
            end
            MODE_DQ_BS:
            begin
                // The backslash survives unless it escapes one of the special bytes.
                if (!(in_byte inside {CH_DQUOTE, CH_BSLASH, CH_BTICK, CH_DOLLAR, CH_NL}))
                    b = add_res(b, KIND_BYTE, CH_BSLASH);
                b = add_res(b, KIND_BYTE, in_byte);
                m = MODE_DQ;
            end
            MODE_BS:
            begin
                if (in_byte == CH_NL)
                    m = tok_reg ? MODE_TOKEN : MODE_BETWEEN;
                else
                begin
                    b = add_res(b, KIND_BYTE, in_byte);
                    t = 1'b1;
                    m = MODE_TOKEN;
                end
            end
            MODE_COMMENT:
            begin
                if (in_byte == CH_NL)
                    m = MODE_BETWEEN;
            end
            default:
            begin
                if (in_byte inside {CH_SPACE, CH_TAB, CH_NL})
                begin
                    if (tok_reg)
                        b = add_res(b, KIND_END, 8'd0);
                    t = 1'b0;
                    m = MODE_BETWEEN;
                end
                else if (in_byte == CH_HASH && !tok_reg)
                    m = MODE_COMMENT;
                else if (in_byte == CH_SQUOTE)
                begin
                    t = 1'b1;
                    m = MODE_SQ;
                end
                else if (in_byte == CH_DQUOTE)
                begin
                    t = 1'b1;
                    m = MODE_DQ;
                end
                else if (in_byte == CH_BSLASH)
                    m = MODE_BS;
                else
                begin
                    b = add_res(b, KIND_BYTE, in_byte);
                    t = 1'b1;
                    m = MODE_TOKEN;
                end
            end
        endcase

        if (last_byte)
        begin
            if (m == MODE_SQ || m == MODE_DQ || m == MODE_DQ_BS)
                b = add_res(b, KIND_BAD, 8'd0);
            else
            begin
                if (t)
                    b = add_res(b, KIND_END, 8'd0);
                b = add_res(b, KIND_EOL, 8'd0);
            end
            m = MODE_BETWEEN;
            t = 1'b0;
        end

        mode_next = m;
        tok_next  = t;
        bnd       = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            tok_reg  <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            tok_reg  <= tok_next;
        end
    end

    // Bytes that produce nothing are not queued.
    assign wr_en   = take && (bnd.cnt != '0);
    assign wr_data = bnd;

endmodule

// File: hdl/sat_queue.sv
// Small queue of result bundles between the lexer and the serialiser.
`timescale 1ns / 1ps
`include "shell_argument_tokenizer_macros.svh"

module sat_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  sat_pkg::bundle_t wr_data,
    input  logic             rd_en,
    output sat_pkg::bundle_t rd_data,
    output logic             full,
    output logic             empty
);
    import sat_pkg::*;

    bundle_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + QCNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    `SAT_ASSERT_NOW(a_no_write_when_full, wr_en, !full)
    `SAT_ASSERT_NOW(a_no_read_when_empty, rd_en, !empty)
    `SAT_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= QCNT_W'(QDEPTH))
    `SAT_ASSERT_NEXT(a_pop_only_drains, rd_en && !wr_en, count_reg == $past(count_reg) - QCNT_W'(1))
    `SAT_ASSERT_NOW(a_queued_not_empty, !empty, rd_data.cnt != '0)

endmodule

// File: hdl/sat_back.sv
// Serialiser: hands out the results of the oldest bundle one beat at a time.
`timescale 1ns / 1ps

module sat_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sat_pkg::bundle_t head,
    input  logic             q_empty,
    input  logic             pop,
    output logic             q_rd_en,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic             run_end
);
    import sat_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             beat;

    assign kind     = head.res[idx_reg].kind;
    assign out_byte = head.res[idx_reg].data;
    assign run_end  = (CNT_W'(idx_reg) == head.cnt - CNT_W'(1));

    assign beat    = pop && !q_empty;
    // The bundle leaves the queue with its final beat.
    assign q_rd_en = beat && run_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (q_rd_en)
            idx_next = '0;
        else if (beat)
            idx_next = idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule
